// ===== rtl/aes128_block_cipher_macros.svh =====
// Assertion macros shared by the AES-128 cipher RTL.
// No dependencies; included by the files that carry assertions.
`ifndef AES128_BLOCK_CIPHER_MACROS_SVH
`define AES128_BLOCK_CIPHER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AES_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define AES_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/aes_pkg.sv =====
// Shared types, constants and S-box tables for the AES-128 cipher.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package aes_pkg;

  localparam int NUM_ROUNDS = 10;
  localparam int RK_IDX_W   = 4;
  localparam int HALF_W     = 64;
  localparam int BLOCK_W    = 128;
  localparam int CFG_IDX_W  = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b1;

  // Command field codes.
  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_RUN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load;
    logic                step;
    logic                last;
    logic                decrypt;
    logic                kx_init;
    logic                kx_step;
    logic [RK_IDX_W-1:0] rk_idx;
  } dp_cmd_t;

  // Forward S-box, entry 0 in the top byte.
  localparam logic [2047:0] SBOX_TBL = {
    128'h637c777bf26b6fc53001672bfed7ab76,
    128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115,
    128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84,
    128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8,
    128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973,
    128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479,
    128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
    128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df,
    128'h8ca1890dbfe6426841992d0fb054bb16
  };

  // Inverse S-box, entry 0 in the top byte.
  localparam logic [2047:0] INV_SBOX_TBL = {
    128'h52096ad53036a538bf40a39e81f3d7fb,
    128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e,
    128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692,
    128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506,
    128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673,
    128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b,
    128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f,
    128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961,
    128'h172b047eba77d626e169146355210c7d
  };

  function automatic logic [7:0] sbox(input logic [7:0] b);
    return SBOX_TBL[{~b, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] b);
    return INV_SBOX_TBL[{~b, 3'b000} +: 8];
  endfunction

  // Multiply by x modulo the field polynomial.
  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/aes_ctrl.sv =====
// Controller for the AES-128 cipher: sequences key expansion and rounds.
// Depends on aes_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "aes128_block_cipher_macros.svh"
module aes_ctrl (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           start,
  input  wire                           command,
  input  wire                           key_write,
  output logic                          busy,
  output logic                          done,
  output aes_pkg::dp_cmd_t              cmd
);
  import aes_pkg::*;

  localparam logic [RK_IDX_W-1:0] LAST_CNT = RK_IDX_W'(NUM_ROUNDS);

  state_t              state, state_next;
  logic [RK_IDX_W-1:0] cnt, cnt_next;
  logic                dec;

  // Next state; a key write always restarts the expansion.
  always_comb begin
    state_next = state;
    if (key_write) begin
      state_next = ST_EXPAND;
    end else begin
      unique case (state)
        ST_IDLE:   if (start) state_next = ST_RUN;
        ST_EXPAND: if (cnt == LAST_CNT) state_next = ST_IDLE;
        ST_RUN:    if (cnt == LAST_CNT) state_next = ST_IDLE;
        default:   state_next = ST_IDLE;
      endcase
    end
  end

  // Round and expansion counter.
  always_comb begin
    cnt_next = cnt;
    if (key_write) begin
      cnt_next = '0;
    end else begin
      unique case (state)
        ST_IDLE:   cnt_next = start ? RK_IDX_W'(1) : '0;
        ST_EXPAND: cnt_next = (cnt == LAST_CNT) ? '0 : cnt + 1'b1;
        ST_RUN:    cnt_next = (cnt == LAST_CNT) ? '0 : cnt + 1'b1;
        default:   cnt_next = '0;
      endcase
    end
  end

  // Datapath commands.
  always_comb begin
    cmd     = '0;
    busy    = (state != ST_IDLE);
    cmd.decrypt = dec;
    unique case (state)
      ST_IDLE: begin
        cmd.load    = start;
        cmd.rk_idx  = (command == CMD_DECRYPT) ? LAST_CNT : '0;
      end
      ST_EXPAND: begin
        cmd.kx_init = (cnt == '0);
        cmd.kx_step = (cnt != '0);
        cmd.rk_idx  = cnt;
      end
      ST_RUN: begin
        cmd.step    = 1'b1;
        cmd.last    = (cnt == LAST_CNT);
        cmd.rk_idx  = dec ? (LAST_CNT - cnt) : cnt;
      end
      default: cmd = '0;
    endcase
  end

  // State, counter and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EXPAND;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= (state == ST_RUN) && (cnt == LAST_CNT);
    end
  end

  // Direction of the request in flight.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      dec <= command;
    end
  end

  `AES_ASSERT_NOW(a_done_not_run, clk, rst, done, state != ST_RUN, "result strobe while running")
  `AES_ASSERT_NOW(a_run_cnt, clk, rst, state == ST_RUN, cnt >= 1 && cnt <= LAST_CNT, "round count out of range")
  `AES_ASSERT_NEXT(a_accept_busy, clk, rst, state == ST_IDLE && start, busy, "accepted request left block idle")

endmodule
`default_nettype wire

// ===== rtl/aes_dp.sv =====
// Datapath for the AES-128 cipher: key registers, round key store,
// key expansion step and one encrypt or decrypt round per cycle. Uses aes_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aes_dp (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               write_enable,
  input  wire [aes_pkg::CFG_IDX_W-1:0]      index,
  input  wire [aes_pkg::HALF_W-1:0]         write_data,
  input  aes_pkg::dp_cmd_t                  cmd,
  input  wire [aes_pkg::HALF_W-1:0]         block_high,
  input  wire [aes_pkg::HALF_W-1:0]         block_low,
  output logic [aes_pkg::HALF_W-1:0]        result_high,
  output logic [aes_pkg::HALF_W-1:0]        result_low
);
  import aes_pkg::*;

  logic [HALF_W-1:0]  key_high, key_low;
  logic [BLOCK_W-1:0] rk_store [NUM_ROUNDS+1];
  logic [BLOCK_W-1:0] kx, kx_next;
  logic [7:0]         rcon;
  logic [BLOCK_W-1:0] st, rk, enc_t, enc_out, dec_t, dec_out;

  // Byte k of the block sits at bits 127-8k down.
  function automatic logic [BLOCK_W-1:0] sub_bytes(input logic [BLOCK_W-1:0] s,
                                                   input logic inv);
    logic [BLOCK_W-1:0] o;
    for (int i = 0; i < 16; i++) begin
      o[8*i +: 8] = inv ? inv_sbox(s[8*i +: 8]) : sbox(s[8*i +: 8]);
    end
    return o;
  endfunction

  // Row r, column c is byte r+4c; forward shifts row r left by r.
  function automatic logic [BLOCK_W-1:0] shift_rows(input logic [BLOCK_W-1:0] s,
                                                    input logic inv);
    logic [BLOCK_W-1:0] o;
    int src, dst;
    o = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        src = r + 4 * ((c + r) % 4);
        dst = r + 4 * c;
        if (inv) o[127-8*src -: 8] = s[127-8*dst -: 8];
        else     o[127-8*dst -: 8] = s[127-8*src -: 8];
      end
    end
    return o;
  endfunction

  // Product with one MixColumns coefficient, selected by its position.
  function automatic logic [7:0] mul_coef(input logic [7:0] a, input int pos,
                                          input logic inv);
    logic [7:0] a2, a4, a8;
    a2 = xtime(a);
    a4 = xtime(a2);
    a8 = xtime(a4);
    if (!inv) begin
      if (pos == 0)      return a2;
      else if (pos == 1) return a2 ^ a;
      else               return a;
    end else begin
      if (pos == 0)      return a8 ^ a4 ^ a2;
      else if (pos == 1) return a8 ^ a2 ^ a;
      else if (pos == 2) return a8 ^ a4 ^ a;
      else               return a8 ^ a;
    end
  endfunction

  function automatic logic [BLOCK_W-1:0] mix_columns(input logic [BLOCK_W-1:0] s,
                                                     input logic inv);
    logic [BLOCK_W-1:0] o;
    logic [7:0]         acc;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = '0;
        for (int k = 0; k < 4; k++) begin
          acc ^= mul_coef(s[127-8*(4*c+k) -: 8], (k - r + 4) % 4, inv);
        end
        o[127-8*(4*c+r) -: 8] = acc;
      end
    end
    return o;
  endfunction

  // Configuration writes; both key registers clear on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (write_enable) begin
      unique case (index)
        REG_KEY_HIGH: key_high <= write_data;
        REG_KEY_LOW:  key_low  <= write_data;
        default:      key_high <= key_high;
      endcase
    end
  end

  // One key expansion step: four new words from the previous round key.
  always_comb begin
    logic [31:0] t, w4, w5, w6, w7;
    t  = {kx[23:0], kx[31:24]};
    t  = {sbox(t[31:24]) ^ rcon, sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0])};
    w4 = kx[127:96] ^ t;
    w5 = kx[95:64] ^ w4;
    w6 = kx[63:32] ^ w5;
    w7 = kx[31:0] ^ w6;
    kx_next = {w4, w5, w6, w7};
  end

  // Round key store and expansion registers.
  always_ff @(posedge clk) begin
    if (cmd.kx_init) begin
      kx                    <= {key_high, key_low};
      rcon                  <= 8'h01;
      rk_store[cmd.rk_idx]  <= {key_high, key_low};
    end else if (cmd.kx_step) begin
      kx                    <= kx_next;
      rcon                  <= xtime(rcon);
      rk_store[cmd.rk_idx]  <= kx_next;
    end
  end

  assign rk = rk_store[cmd.rk_idx];

  // One round in either direction.
  always_comb begin
    enc_t   = shift_rows(sub_bytes(st, 1'b0), 1'b0);
    enc_out = (cmd.last ? enc_t : mix_columns(enc_t, 1'b0)) ^ rk;
    dec_t   = sub_bytes(shift_rows(st, 1'b1), 1'b1) ^ rk;
    dec_out = cmd.last ? dec_t : mix_columns(dec_t, 1'b1);
  end

  // Block state register; it holds the result once the last round is done.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      st <= {block_high, block_low} ^ rk;
    end else if (cmd.step) begin
      st <= cmd.decrypt ? dec_out : enc_out;
    end
  end

  assign result_high = st[BLOCK_W-1:HALF_W];
  assign result_low  = st[HALF_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/aes128_block_cipher.sv =====
// AES-128 ECB cipher: a request is accepted when start is high and busy low;
// the initial key addition and ten rounds follow, one round key read per cycle.
// The result strobe done rises together with the result once the last round
// is done; busy stays high until then, so no new request is taken before.
// Reset and every key write start a key expansion with busy high.
// The strobe done is high for a single cycle; the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none
module aes128_block_cipher (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           start,
  output logic                          busy,
  input  wire                           command,
  input  wire [aes_pkg::HALF_W-1:0]     block_high,
  input  wire [aes_pkg::HALF_W-1:0]     block_low,
  output logic                          done,
  output logic [aes_pkg::HALF_W-1:0]    result_high,
  output logic [aes_pkg::HALF_W-1:0]    result_low,
  input  wire                           write_enable,
  input  wire [aes_pkg::CFG_IDX_W-1:0]  index,
  input  wire [aes_pkg::HALF_W-1:0]     write_data
);
  import aes_pkg::*;

  dp_cmd_t cmd;

  // Sequencing of expansion and rounds.
  aes_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .command   (command),
    .key_write (write_enable),
    .busy      (busy),
    .done      (done),
    .cmd       (cmd)
  );

  // Key store and round logic.
  aes_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .index        (index),
    .write_data   (write_data),
    .cmd          (cmd),
    .block_high   (block_high),
    .block_low    (block_low),
    .result_high  (result_high),
    .result_low   (result_low)
  );

endmodule
`default_nettype wire
